[rtl/qbpd_pkg.sv]
// Shared constants and types for the four-button press-duration classifier.
`default_nettype none

package qbpd_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int TIME_BITS   = 32;
    localparam int IN_TIME_W   = 32;
    localparam int BTN_W       = 2;
    localparam int ACT_W       = 3;
    localparam int ST_W        = 2;
    localparam int THR_W       = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam logic [ST_W-1:0] ST_RELEASED = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESSED  = 2'd1;
    localparam logic [ST_W-1:0] ST_LONG     = 2'd2;
    localparam logic [ST_W-1:0] ST_EXTRA    = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE = ACT_W'(NUM_BUTTONS);

    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXTRA_PRESS = 2'd1;

    localparam logic [THR_W-1:0] LONG_PRESS_RESET  = 32'd1000;
    localparam logic [THR_W-1:0] EXTRA_PRESS_RESET = 32'd3000;

    typedef struct packed {
        logic [BTN_W-1:0] button_index;
        logic [ST_W-1:0]  event_state;
        logic             last_event;
    } event_t;

    typedef struct packed {
        logic [ACT_W-1:0]     active;
        logic [ST_W-1:0]      state;
        logic [TIME_BITS-1:0] press_time;
        logic [1:0]           num_events;
        event_t               ev0;
        event_t               ev1;
    } scan_result_t;

endpackage

`default_nettype wire

[rtl/qbpd_scan.sv]
// One scan of all buttons: next held-button state and up to two events.
`default_nettype none

module qbpd_scan (
    input  wire logic [qbpd_pkg::ACT_W-1:0]       active,
    input  wire logic [qbpd_pkg::ST_W-1:0]        state,
    input  wire logic [qbpd_pkg::TIME_BITS-1:0]   press_time,
    input  wire logic [qbpd_pkg::TIME_BITS-1:0]   now,
    input  wire logic [qbpd_pkg::NUM_BUTTONS-1:0] input_on,
    input  wire logic [qbpd_pkg::NUM_BUTTONS-1:0] signal_ok,
    input  wire logic [qbpd_pkg::THR_W-1:0]       long_press_ms,
    input  wire logic [qbpd_pkg::THR_W-1:0]       extra_long_press_ms,
    output qbpd_pkg::scan_result_t                result
);
    import qbpd_pkg::*;

    logic [TIME_BITS-1:0] held;
    logic [THR_W-1:0]     held_ext;
    logic [BTN_W-1:0]     act_idx;
    logic                 none_active;
    logic                 act_ok;
    logic                 act_on;
    logic                 released_now;
    logic                 search_en;
    logic [ACT_W-1:0]     search_lo;
    logic                 found;
    logic [BTN_W-1:0]     found_idx;
    logic                 first_valid;
    event_t               first_ev;
    logic [ST_W-1:0]      held_next;

    assign none_active = (active == ACT_NONE);
    assign act_idx     = active[BTN_W-1:0];
    assign act_ok      = !none_active && signal_ok[act_idx];
    assign act_on      = input_on[act_idx];
    assign held        = now - press_time;
    assign held_ext    = THR_W'(held);

    assign released_now = act_ok && !act_on && (state != ST_RELEASED);
    assign search_en    = none_active || released_now;
    assign search_lo    = none_active ? '0 : active + ACT_W'(1);

    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (signal_ok[i] && input_on[i] && (ACT_W'(i) >= search_lo)) begin
                found     = 1'b1;
                found_idx = BTN_W'(i);
            end
        end
    end

    always_comb begin
        held_next = state;
        unique case (state)
            ST_RELEASED: held_next = ST_RELEASED;
            ST_PRESSED:  if (held_ext >= long_press_ms) held_next = ST_LONG;
            ST_LONG:     if (held_ext >= extra_long_press_ms) held_next = ST_EXTRA;
            ST_EXTRA:    held_next = ST_EXTRA;
            default:     held_next = state;
        endcase
    end

    always_comb begin
        first_valid           = 1'b0;
        first_ev.button_index = act_idx;
        first_ev.event_state  = ST_RELEASED;
        first_ev.last_event   = 1'b0;
        if (released_now) begin
            first_valid = 1'b1;
        end else if (act_ok && act_on && (held_next != state)) begin
            first_valid          = 1'b1;
            first_ev.event_state = held_next;
        end
    end

    always_comb begin
        result.active     = active;
        result.state      = state;
        result.press_time = press_time;
        result.num_events = 2'd0;
        result.ev0        = first_ev;
        result.ev1.button_index = found_idx;
        result.ev1.event_state  = ST_PRESSED;
        result.ev1.last_event   = 1'b1;

        if (released_now) begin
            result.active     = ACT_NONE;
            result.state      = ST_RELEASED;
            result.press_time = '0;
        end else if (act_ok && act_on) begin
            result.state = held_next;
        end

        if (search_en && found) begin
            result.active     = ACT_W'(found_idx);
            result.state      = ST_PRESSED;
            result.press_time = now;
        end

        if (first_valid && search_en && found) begin
            result.num_events = 2'd2;
        end else if (first_valid) begin
            result.num_events     = 2'd1;
            result.ev0.last_event = 1'b1;
        end else if (search_en && found) begin
            result.num_events       = 2'd1;
            result.ev0.button_index = found_idx;
            result.ev0.event_state  = ST_PRESSED;
            result.ev0.last_event   = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/quad_button_press_duration_classifier.sv]
// Top level of the four-button press-duration classifier with stream ports.
//
// Each transfer on the s_ side is one scan of four buttons. The block keeps one
// held button and its press time, and reports every state change (released,
// pressed, long, extra long) as one transfer on the m_ side, with m_tlast set
// on the last event of a scan. A scan passes an input register and then
// combinational scan logic into a two-entry result buffer; a scan is accepted
// every cycle while m_tready is high and no scan has two events, as a two-event
// scan holds off the next until its first event drains. Thresholds must be
// written through the cfg_ port while the block is idle; nothing enforces it.
`default_nettype none

module quad_button_press_duration_classifier (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // time_ms [31:0], input_on [35:32], signal_ok [39:36]
    input  wire logic [qbpd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // button_index [1:0], event_state [3:2], zero [7:4]
    output logic [qbpd_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [qbpd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [qbpd_pkg::THR_W-1:0]        cfg_wdata
);
    import qbpd_pkg::*;

    logic [THR_W-1:0] long_press_reg;
    logic [THR_W-1:0] extra_press_reg;

    logic                   in_valid_reg;
    logic [IN_TIME_W-1:0]   in_time_reg;
    logic [NUM_BUTTONS-1:0] in_on_reg;
    logic [NUM_BUTTONS-1:0] in_ok_reg;

    logic [ACT_W-1:0]     active_reg;
    logic [ST_W-1:0]      state_reg;
    logic [TIME_BITS-1:0] press_reg;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    event_t     slot0_reg;
    event_t     slot0_next;
    event_t     slot1_reg;
    event_t     slot1_next;

    scan_result_t scan;
    logic         pop;
    logic         room;
    logic         proc_fire;
    logic         s_fire;

    assign pop       = (cnt_reg != 2'd0) && m_tready;
    assign room      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign proc_fire = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg  <= LONG_PRESS_RESET;
            extra_press_reg <= EXTRA_PRESS_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_LONG_PRESS) begin
                long_press_reg <= cfg_wdata;
            end else if (cfg_addr == CFG_EXTRA_PRESS) begin
                extra_press_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_time_reg <= s_tdata[IN_TIME_W-1:0];
            in_on_reg   <= s_tdata[IN_TIME_W +: NUM_BUTTONS];
            in_ok_reg   <= s_tdata[IN_TIME_W + NUM_BUTTONS +: NUM_BUTTONS];
        end
    end

    qbpd_scan u_scan (
        .active              (active_reg),
        .state               (state_reg),
        .press_time          (press_reg),
        .now                 (in_time_reg[TIME_BITS-1:0]),
        .input_on            (in_on_reg),
        .signal_ok           (in_ok_reg),
        .long_press_ms       (long_press_reg),
        .extra_long_press_ms (extra_press_reg),
        .result              (scan)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACT_NONE;
            state_reg  <= ST_RELEASED;
            press_reg  <= '0;
        end else if (proc_fire) begin
            active_reg <= scan.active;
            state_reg  <= scan.state;
            press_reg  <= scan.press_time;
        end
    end

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (proc_fire) begin
            cnt_next   = scan.num_events;
            slot0_next = scan.ev0;
            slot1_next = scan.ev1;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = M_TDATA_W'({slot0_reg.event_state, slot0_reg.button_index});
    assign m_tlast  = slot0_reg.last_event;

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the four-button press-duration classifier.
module tb;
    import qbpd_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_TIME = 4000000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 2'd3;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [THR_W-1:0] cfg_wdata = '0;

    // Predicted classifier state and thresholds.
    logic [ST_W-1:0] btn_st [NUM_BUTTONS];
    logic [TIME_BITS-1:0] btn_t0 [NUM_BUTTONS];
    logic [ACT_W-1:0] held_btn;
    logic [THR_W-1:0] thr_long;
    logic [THR_W-1:0] thr_extra;

    event_t pending_events [$];
    event_t expected_head;
    int mismatch_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    logic [31:0] scan_ms = '0;

    quad_button_press_duration_classifier dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_st[i] = ST_RELEASED;
            btn_t0[i] = '0;
        end
        held_btn = ACT_NONE;
        thr_long = LONG_PRESS_RESET;
        thr_extra = EXTRA_PRESS_RESET;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(string what, int unsigned got_val, int unsigned want_val);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got_val, want_val);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("result with none pending, tdata", m_tdata, 0);
            end else begin
                expected_head = pending_events.pop_front();
                if (m_tdata[1:0] != expected_head.button_index)
                    report_mismatch("button_index", m_tdata[1:0], expected_head.button_index);
                if (m_tdata[3:2] != expected_head.event_state)
                    report_mismatch("event_state", m_tdata[3:2], expected_head.event_state);
                if (m_tlast != expected_head.last_event)
                    report_mismatch("last_event", m_tlast, expected_head.last_event);
            end
        end
    end

    function automatic void classify_scan(logic [31:0] t, logic [3:0] on_bits,
                                          logic [3:0] ok_bits);
        event_t evs [$];
        logic [ST_W-1:0] cur;
        logic [ST_W-1:0] nxt;
        logic [TIME_BITS-1:0] dur;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            cur = btn_st[i];
            nxt = cur;
            if (held_btn != ACT_NONE && held_btn != ACT_W'(i)) continue;
            if (!ok_bits[i]) continue;
            dur = t - btn_t0[i];
            if (on_bits[i]) begin
                case (cur)
                    ST_RELEASED: begin
                        held_btn = ACT_W'(i);
                        btn_t0[i] = t;
                        nxt = ST_PRESSED;
                    end
                    ST_PRESSED: if (dur >= thr_long) nxt = ST_LONG;
                    ST_LONG: if (dur >= thr_extra) nxt = ST_EXTRA;
                    default: ;
                endcase
            end else if (cur != ST_RELEASED) begin
                held_btn = ACT_NONE;
                btn_t0[i] = '0;
                nxt = ST_RELEASED;
            end
            if (nxt != cur) begin
                btn_st[i] = nxt;
                evs.push_back('{button_index: BTN_W'(i), event_state: nxt, last_event: 1'b0});
            end
        end
        if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
        foreach (evs[k]) pending_events.push_back(evs[k]);
    endfunction

    task automatic send_scan(logic [31:0] t, logic [3:0] on_bits, logic [3:0] ok_bits);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ok_bits, on_bits, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        classify_scan(t, on_bits, ok_bits);
    endtask

    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [THR_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (addr)
            CFG_LONG_PRESS: thr_long = data;
            CFG_EXTRA_PRESS: thr_extra = data;
            default: ;
        endcase
    endtask

    task automatic test_default_thresholds();
        send_scan(32'd100, 4'b0001, 4'b0001);
        send_scan(32'd1099, 4'b0001, 4'b0001);
        send_scan(32'd1100, 4'b0001, 4'b0001);
        send_scan(32'd3099, 4'b0001, 4'b0001);
        send_scan(32'd3100, 4'b0001, 4'b0001);
        send_scan(32'd9000, 4'b0001, 4'b0001);
        send_scan(32'd9001, 4'b0000, 4'b0001);
        // Releasing buttons that are already released must stay silent.
        send_scan(32'd9002, 4'b0000, 4'b1111);
        settle_idle();
    endtask

    task automatic test_hold_lockout();
        send_scan(32'd200, 4'b0100, 4'b0100);
        send_scan(32'd210, 4'b1111, 4'b1011);
        send_scan(32'd220, 4'b1010, 4'b1111);
        send_scan(32'd230, 4'b0001, 4'b1111);
        send_scan(32'd240, 4'b1111, 4'b1111);
        send_scan(32'd250, 4'b0000, 4'b0000);
        send_scan(32'd260, 4'b0000, 4'b0001);
        settle_idle();
    endtask

    task automatic test_time_wrap();
        send_scan(32'hFFFF_FF00, 4'b0010, 4'b0010);
        send_scan(32'h0000_02E7, 4'b0010, 4'b0010);
        send_scan(32'h0000_02E8, 4'b0010, 4'b0010);
        send_scan(32'h0000_3000, 4'b0000, 4'b0010);
        settle_idle();
    endtask

    task automatic test_threshold_extremes();
        write_reg(CFG_LONG_PRESS, '0);
        write_reg(CFG_EXTRA_PRESS, '0);
        repeat (4) send_scan(32'd7, 4'b0010, 4'b0010);
        send_scan(32'd8, 4'b0000, 4'b0010);
        settle_idle();
        write_reg(CFG_LONG_PRESS, '1);
        write_reg(CFG_EXTRA_PRESS, '1);
        send_scan(32'd5, 4'b1000, 4'b1000);
        send_scan(32'd4, 4'b1000, 4'b1000);
        send_scan(32'd3, 4'b1000, 4'b1000);
        send_scan(32'd4, 4'b1000, 4'b1000);
        send_scan(32'd6, 4'b0000, 4'b1000);
        settle_idle();
    endtask

    task automatic test_ignored_writes();
        write_reg(CFG_SPARE_A, '0);
        write_reg(CFG_SPARE_B, '0);
        send_scan(32'd0, 4'b0100, 4'b0100);
        send_scan(32'd1, 4'b0100, 4'b0100);
        send_scan(32'd2, 4'b0000, 4'b0100);
        settle_idle();
    endtask

    task automatic test_random_hold_sequences(int gap, int stall, int count);
        int sent;
        int btn;
        int hold;
        logic [3:0] scan_on;
        logic [3:0] scan_ok;
        sent = 0;
        write_reg(CFG_LONG_PRESS, THR_W'($urandom_range(0, 200)));
        write_reg(CFG_EXTRA_PRESS, THR_W'($urandom_range(0, 400)));
        gap_pct = gap;
        stall_pct = stall;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                btn = (held_btn != ACT_NONE) ? int'(held_btn) : $urandom_range(NUM_BUTTONS - 1);
                hold = $urandom_range(1, 12);
                for (int k = 0; k <= hold; k++) begin
                    scan_on = 4'($urandom);
                    scan_ok = 4'($urandom);
                    if (k < hold) begin
                        scan_on[btn] = 1'b1;
                        if ($urandom_range(9) != 0) scan_ok[btn] = 1'b1;
                    end else begin
                        scan_on[btn] = 1'b0;
                        scan_ok[btn] = 1'b1;
                    end
                    scan_ms += $urandom_range(0, 60);
                    send_scan(scan_ms, scan_on, scan_ok);
                    sent++;
                end
            end else begin
                if ($urandom_range(1) == 0) scan_ms = $urandom;
                else scan_ms += $urandom_range(0, 100);
                send_scan(scan_ms, 4'($urandom), 4'($urandom));
            end
            if ($urandom_range(99) < 2) settle_idle();
        end
        settle_idle();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_thresholds();
        test_hold_lockout();
        test_time_wrap();
        test_threshold_extremes();
        test_ignored_writes();
        test_random_hold_sequences(0, 0, 250);
        test_random_hold_sequences(53, 0, 250);
        test_random_hold_sequences(0, 53, 250);
        test_random_hold_sequences(7, 7, 250);
        settle_idle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/qbpd_pkg.sv
rtl/qbpd_scan.sv
rtl/quad_button_press_duration_classifier.sv
tb/tb.sv
